// File: hdl/uer_pkg.sv
// Package for the ultrasonic echo ranger: field widths, register indexes,
// payload structs and controller/datapath command and status types.
// No dependencies.
package uer_pkg;

   localparam int ECHO_COUNT_BITS_DEF = 16;
   localparam int MAX_SAMPLES_DEF     = 16;

   localparam int TRIG_W   = 8;
   localparam int SAMP_W   = 5;
   localparam int TIMER_W  = 18;
   localparam int SCALE_W  = 16;
   localparam int SUM_W    = 18;
   localparam int DIST_W   = 14;
   localparam int DIV_W    = SUM_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int REM_W    = SAMP_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_GAP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE         = 3'd3;

   localparam logic [TRIG_W-1:0]  TRIG_WIDTH_RST = 8'd10;
   localparam logic [SAMP_W-1:0]  SAMPLES_RST    = 5'd1;
   localparam logic [TIMER_W-1:0] SAMPLE_GAP_RST = 18'd250000;
   localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd11249;

   localparam logic [DIST_W-1:0]  DIST_MAX     = 14'h3FFF;
   localparam logic [SUM_W-1:0]   SUM_MAX      = 18'h3FFFF;
   localparam logic [SAMP_W-1:0]  SAMPLES_SAT  = 5'h1F;
   localparam int                 ROUND_HALF   = 32768;
   localparam int                 FRAC_BITS    = 16;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_TRIG = 5'b00010,
      PH_WAIT = 5'b00100,
      PH_HIGH = 5'b01000,
      PH_GAP  = 5'b10000
   } phase_type;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EVAL = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_ACC  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } ctl_state_type;

   typedef struct packed {
      logic echo_level;
      logic start_request;
   } req_payload_type;

   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] distance_tenths_cm;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic step;
      logic mul;
      logic acc;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_mul;
      logic need_div;
      logic div_last;
   } dp_status_type;

endpackage

// File: hdl/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger top level: joins the sequencer and the datapath.
// Depends on uer_pkg, uer_ctrl and uer_dpath.
//
// Usage: each req_ transfer is one microsecond tick carrying the sampled echo
// pin level and a start request; each tick yields exactly one rsp_ transfer
// with the trigger pin level, busy, a one-tick done flag and the last
// averaged distance in tenths of a centimetre. A start while idle fires the
// trigger, times the echo, converts it with the Q0.16 scale and repeats for
// the configured sample count with a gap after each, then averages.
// One tick at a time: req_stall is high until the sequencer is back in idle.
// A plain tick goes from evaluate to the output register, a tick on the
// falling echo edge goes through a multiply step, then round and
// accumulate, and the tick that stores the average goes through the
// bit-serial divider (19 steps) and a finish step.
// The csr_ port writes registers by index; write only while no tick is open.
// Reset (synchronous) restores register defaults and the idle phase. While
// rsp_stall is high the result holds in the output register; the next tick is
// still taken and computed, and waits until that register drains.
module ultrasonic_echo_ranger_unit #(
   parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF,
   parameter int MAX_SAMPLES     = uer_pkg::MAX_SAMPLES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  uer_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output uer_pkg::rsp_payload_type       rsp_payload
);

   uer_pkg::ctl_cmd_type   cmd;
   uer_pkg::dp_status_type status;

   uer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   uer_dpath #(
      .ECHO_COUNT_BITS (ECHO_COUNT_BITS),
      .MAX_SAMPLES     (MAX_SAMPLES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: hdl/uer_ctrl.sv
// Sequencer for the echo ranger: walks one tick through evaluate, multiply,
// accumulate or divide, then loads the output register. Uses uer_pkg.
module uer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  uer_pkg::dp_status_type status,
   output uer_pkg::ctl_cmd_type   cmd
);

   uer_pkg::ctl_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != uer_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         uer_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = uer_pkg::S_EVAL;
            end
         end
         uer_pkg::S_EVAL: begin
            if (status.need_mul) begin
               state_in = uer_pkg::S_MUL;
            end else if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = uer_pkg::S_DIV;
            end else begin
               cmd.step = 1'b1;
               state_in = uer_pkg::S_OUT;
            end
         end
         uer_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = uer_pkg::S_ACC;
         end
         uer_pkg::S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = uer_pkg::S_OUT;
         end
         uer_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = uer_pkg::S_FIN;
            end
         end
         uer_pkg::S_FIN: begin
            cmd.div_finish = 1'b1;
            state_in       = uer_pkg::S_OUT;
         end
         uer_pkg::S_OUT: begin
            // hold until the output register is free or drains this cycle
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = uer_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = uer_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uer_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == uer_pkg::S_EVAL))
      else $error("accepted transfer did not move to evaluate");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");
   a_mul_to_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == uer_pkg::S_MUL) |=> (state_ff == uer_pkg::S_ACC))
      else $error("multiply not followed by accumulate");
`endif

endmodule

// File: hdl/uer_dpath.sv
// Datapath for the echo ranger: config registers, phase state, echo counter,
// scaling multiplier, sum, serial divider and output register. Uses uer_pkg.
module uer_dpath #(
   parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF,
   parameter int MAX_SAMPLES     = uer_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [uer_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  uer_pkg::req_payload_type            req_payload,
   output uer_pkg::rsp_payload_type            rsp_payload,
   input  uer_pkg::ctl_cmd_type                cmd,
   output uer_pkg::dp_status_type              status
);

   localparam int PROD_W = ECHO_COUNT_BITS + uer_pkg::SCALE_W;
   localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = {ECHO_COUNT_BITS{1'b1}};

   // configuration
   logic [uer_pkg::TRIG_W-1:0]  trig_width_ff;
   logic [uer_pkg::SAMP_W-1:0]  samples_cfg_ff;
   logic [uer_pkg::TIMER_W-1:0] gap_ff;
   logic [uer_pkg::SCALE_W-1:0] scale_ff;

   // latched tick
   logic echo_ff, start_ff;

   // sequence state
   uer_pkg::phase_type           phase_ff, phase_in;
   logic [uer_pkg::TIMER_W-1:0]  timer_ff, timer_in;
   logic [ECHO_COUNT_BITS-1:0]   echo_count_ff, echo_count_in;
   logic [uer_pkg::SAMP_W-1:0]   samples_done_ff, samples_done_in;
   logic [uer_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [uer_pkg::DIST_W-1:0]   average_ff, average_in;
   logic                         done_ff, done_in;

   // arithmetic
   logic [PROD_W-1:0]              product_ff;
   logic [PROD_W:0]                rounded;
   logic [PROD_W:0]                dist_wide;
   logic [uer_pkg::DIST_W-1:0]     dist_sat;
   logic [uer_pkg::SUM_W:0]        sum_wide;
   logic [uer_pkg::SAMP_W-1:0]     target_n;
   logic [uer_pkg::SAMP_W-1:0]     divisor_ff;
   logic [uer_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [uer_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [uer_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [uer_pkg::REM_W-1:0]      trial;
   logic                           quo_bit;

   uer_pkg::rsp_payload_type rsp_payload_ff;

   // sample count clamped to one through MAX_SAMPLES
   always_comb begin
      if (samples_cfg_ff == '0) begin
         target_n = uer_pkg::SAMP_W'(1);
      end else if (int'(samples_cfg_ff) > MAX_SAMPLES) begin
         target_n = uer_pkg::SAMP_W'(MAX_SAMPLES);
      end else begin
         target_n = samples_cfg_ff;
      end
   end

   assign status.need_mul = (phase_ff == uer_pkg::PH_HIGH) && !echo_ff;
   assign status.need_div = (phase_ff == uer_pkg::PH_GAP) && (timer_ff >= gap_ff)
                            && (samples_done_ff >= target_n);
   assign status.div_last = (div_cnt_ff == uer_pkg::DIV_CNT_W'(uer_pkg::DIV_W - 1));

   // round half up, drop the fraction, saturate
   assign rounded   = {1'b0, product_ff} + (PROD_W + 1)'(uer_pkg::ROUND_HALF);
   assign dist_wide = rounded >> uer_pkg::FRAC_BITS;
   assign dist_sat  = (dist_wide > (PROD_W + 1)'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                                      : uer_pkg::DIST_W'(dist_wide);
   assign sum_wide  = {1'b0, sum_ff} + (uer_pkg::SUM_W + 1)'(dist_sat);

   // one restoring divide step
   assign trial   = {rem_ff[uer_pkg::REM_W-2:0], quo_ff[uer_pkg::DIV_W-1]};
   assign quo_bit = (trial >= {1'b0, divisor_ff});

   always_comb begin
      phase_in        = phase_ff;
      timer_in        = timer_ff;
      echo_count_in   = echo_count_ff;
      samples_done_in = samples_done_ff;
      sum_in          = sum_ff;
      average_in      = average_ff;
      done_in         = done_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      div_cnt_in      = div_cnt_ff;

      if (cmd.load) begin
         done_in = 1'b0;
      end

      if (cmd.step) begin
         unique case (phase_ff)
            uer_pkg::PH_IDLE: begin
               if (start_ff) begin
                  phase_in        = uer_pkg::PH_TRIG;
                  timer_in        = uer_pkg::TIMER_W'(1);
                  samples_done_in = '0;
                  sum_in          = '0;
                  echo_count_in   = '0;
               end
            end
            uer_pkg::PH_TRIG: begin
               if (timer_ff >= uer_pkg::TIMER_W'(trig_width_ff)) begin
                  phase_in = uer_pkg::PH_WAIT;
                  timer_in = '0;
               end else begin
                  timer_in = timer_ff + uer_pkg::TIMER_W'(1);
               end
            end
            uer_pkg::PH_WAIT: begin
               if (echo_ff) begin
                  phase_in      = uer_pkg::PH_HIGH;
                  echo_count_in = ECHO_COUNT_BITS'(1);
               end
            end
            uer_pkg::PH_HIGH: begin
               // echo still high here; falling edge goes through accumulate
               if (echo_count_ff != ECHO_MAX) begin
                  echo_count_in = echo_count_ff + ECHO_COUNT_BITS'(1);
               end
            end
            uer_pkg::PH_GAP: begin
               // gap expiry with samples complete goes through the divider
               if (timer_ff >= gap_ff) begin
                  phase_in      = uer_pkg::PH_TRIG;
                  timer_in      = uer_pkg::TIMER_W'(1);
                  echo_count_in = '0;
               end else begin
                  timer_in = timer_ff + uer_pkg::TIMER_W'(1);
               end
            end
            default: begin
               phase_in = uer_pkg::PH_IDLE;
               timer_in = '0;
            end
         endcase
      end

      if (cmd.acc) begin
         sum_in = (sum_wide > {1'b0, uer_pkg::SUM_MAX}) ? uer_pkg::SUM_MAX
                                                        : sum_wide[uer_pkg::SUM_W-1:0];
         if (samples_done_ff != uer_pkg::SAMPLES_SAT) begin
            samples_done_in = samples_done_ff + uer_pkg::SAMP_W'(1);
         end
         phase_in = uer_pkg::PH_GAP;
         timer_in = '0;
      end

      if (cmd.div_start) begin
         quo_in     = {1'b0, sum_ff} + uer_pkg::DIV_W'(target_n >> 1);
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         rem_in     = quo_bit ? (trial - {1'b0, divisor_ff}) : trial;
         quo_in     = {quo_ff[uer_pkg::DIV_W-2:0], quo_bit};
         div_cnt_in = div_cnt_ff + uer_pkg::DIV_CNT_W'(1);
      end

      if (cmd.div_finish) begin
         average_in = (quo_ff > uer_pkg::DIV_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                                    : quo_ff[uer_pkg::DIST_W-1:0];
         done_in    = 1'b1;
         phase_in   = uer_pkg::PH_IDLE;
         timer_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_width_ff   <= uer_pkg::TRIG_WIDTH_RST;
         samples_cfg_ff  <= uer_pkg::SAMPLES_RST;
         gap_ff          <= uer_pkg::SAMPLE_GAP_RST;
         scale_ff        <= uer_pkg::SCALE_RST;
         phase_ff        <= uer_pkg::PH_IDLE;
         timer_ff        <= '0;
         echo_count_ff   <= '0;
         samples_done_ff <= '0;
         sum_ff          <= '0;
         average_ff      <= '0;
         done_ff         <= 1'b0;
         div_cnt_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               uer_pkg::CSR_TRIGGER_WIDTH: trig_width_ff <= csr_wdata[uer_pkg::TRIG_W-1:0];
               uer_pkg::CSR_SAMPLES:       samples_cfg_ff <= csr_wdata[uer_pkg::SAMP_W-1:0];
               uer_pkg::CSR_SAMPLE_GAP:    gap_ff <= csr_wdata[uer_pkg::TIMER_W-1:0];
               uer_pkg::CSR_SCALE:         scale_ff <= csr_wdata[uer_pkg::SCALE_W-1:0];
               default: begin
               end
            endcase
         end
         phase_ff        <= phase_in;
         timer_ff        <= timer_in;
         echo_count_ff   <= echo_count_in;
         samples_done_ff <= samples_done_in;
         sum_ff          <= sum_in;
         average_ff      <= average_in;
         done_ff         <= done_in;
         div_cnt_ff      <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         echo_ff  <= req_payload.echo_level;
         start_ff <= req_payload.start_request;
      end
      if (cmd.mul) begin
         product_ff <= PROD_W'(echo_count_ff) * PROD_W'(scale_ff);
      end
      if (cmd.div_start) begin
         divisor_ff <= target_n;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.emit) begin
         rsp_payload_ff.trigger_level      <= (phase_ff == uer_pkg::PH_TRIG);
         rsp_payload_ff.busy_res           <= (phase_ff != uer_pkg::PH_IDLE);
         rsp_payload_ff.done_res           <= done_ff;
         rsp_payload_ff.distance_tenths_cm <= average_ff;
      end
   end

   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (phase_ff == uer_pkg::PH_IDLE))
      else $error("done flagged outside idle phase");
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (rem_ff < {1'b0, divisor_ff}))
      else $error("divider remainder not below divisor");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for ultrasonic_echo_ranger_unit: sends microsecond ticks over the
// req_ channel, predicts every rsp_ transfer and compares it field by field.
// Depends on uer_pkg and the unit under hdl/.
module tb_top;

   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int SAMPLE_CAP = uer_pkg::MAX_SAMPLES_DEF;
   localparam int ECHO_FULL = (1 << uer_pkg::ECHO_COUNT_BITS_DEF) - 1;
   // long enough that an unsaturated count would round one tenth higher at scale 8192
   localparam int SAT_HIGH_TICKS = ECHO_FULL + 10;
   localparam int DIST_SAT_HIGH_TICKS = 16400;
   localparam int RANDOM_TICKS = 550;
   localparam int QUIET_TAIL = 80;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [uer_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   uer_pkg::req_payload_type       req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   uer_pkg::rsp_payload_type       rsp_payload;

   ultrasonic_echo_ranger_unit DUT (.*);

   // predictor copy of the registers and the ranging state
   logic [uer_pkg::TRIG_W-1:0]              cfg_trigger_width;
   logic [uer_pkg::SAMP_W-1:0]              cfg_samples;
   logic [uer_pkg::TIMER_W-1:0]             cfg_gap;
   logic [uer_pkg::SCALE_W-1:0]             cfg_scale;
   uer_pkg::phase_type                      rng_phase;
   logic [uer_pkg::TIMER_W-1:0]             rng_timer;
   logic [uer_pkg::ECHO_COUNT_BITS_DEF-1:0] rng_echo_count;
   logic [uer_pkg::SAMP_W-1:0]              rng_samples_done;
   logic [uer_pkg::SUM_W-1:0]               rng_sum;
   logic [uer_pkg::DIST_W-1:0]              rng_average;

   uer_pkg::rsp_payload_type pending_readings[$];
   int                       failures = 0;
   int                       sequence_ticks = 0;
   int                       cycles = 0;
   int                       stall_left = 0;
   bit                       idling_on = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver backpressure: random stall bursts while idling_on is set
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      uer_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("rsp transfer with nothing expected: %p", rsp_payload);
            failures++;
         end else begin
            want = pending_readings.pop_front();
            check_field("trigger_level", want.trigger_level, rsp_payload.trigger_level);
            check_field("busy_res", want.busy_res, rsp_payload.busy_res);
            check_field("done_res", want.done_res, rsp_payload.done_res);
            check_field("distance_tenths_cm", want.distance_tenths_cm,
                        rsp_payload.distance_tenths_cm);
         end
      end
   end

   function automatic void reset_ranger();
      cfg_trigger_width = uer_pkg::TRIG_WIDTH_RST;
      cfg_samples = uer_pkg::SAMPLES_RST;
      cfg_gap = uer_pkg::SAMPLE_GAP_RST;
      cfg_scale = uer_pkg::SCALE_RST;
      rng_phase = uer_pkg::PH_IDLE;
      rng_timer = '0;
      rng_echo_count = '0;
      rng_samples_done = '0;
      rng_sum = '0;
      rng_average = '0;
   endfunction

   // advance the ranging state by one microsecond tick
   function automatic uer_pkg::rsp_payload_type step_ranger(input logic echo,
                                                            input logic start);
      uer_pkg::rsp_payload_type r;
      logic [32:0]              product;
      logic [16:0]              sample_tenths;
      logic [18:0]              total;
      logic [18:0]              mean;
      logic [uer_pkg::SAMP_W:0] n;
      logic                     done;
      done = 1'b0;
      case (rng_phase)
         uer_pkg::PH_IDLE: begin
            if (start) begin
               rng_phase = uer_pkg::PH_TRIG;
               rng_timer = uer_pkg::TIMER_W'(1);
               rng_samples_done = '0;
               rng_sum = '0;
               rng_echo_count = '0;
            end
         end
         uer_pkg::PH_TRIG: begin
            if (rng_timer >= uer_pkg::TIMER_W'(cfg_trigger_width)) begin
               rng_phase = uer_pkg::PH_WAIT;
               rng_timer = '0;
            end else begin
               rng_timer++;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo) begin
               rng_phase = uer_pkg::PH_HIGH;
               rng_echo_count = uer_pkg::ECHO_COUNT_BITS_DEF'(1);
            end
         end
         uer_pkg::PH_HIGH: begin
            if (echo) begin
               if (rng_echo_count != '1) rng_echo_count++;
            end else begin
               product = 33'(rng_echo_count) * 33'(cfg_scale) + 33'(uer_pkg::ROUND_HALF);
               sample_tenths = product[32:uer_pkg::FRAC_BITS];
               if (sample_tenths > 17'(uer_pkg::DIST_MAX))
                  sample_tenths = 17'(uer_pkg::DIST_MAX);
               total = 19'(rng_sum) + 19'(sample_tenths);
               rng_sum = (total > 19'(uer_pkg::SUM_MAX)) ? uer_pkg::SUM_MAX
                                                         : total[uer_pkg::SUM_W-1:0];
               if (rng_samples_done != uer_pkg::SAMPLES_SAT) rng_samples_done++;
               rng_phase = uer_pkg::PH_GAP;
               rng_timer = '0;
            end
         end
         uer_pkg::PH_GAP: begin
            if (rng_timer >= cfg_gap) begin
               n = (cfg_samples == '0) ? 6'd1 :
                   (cfg_samples > SAMPLE_CAP) ? 6'(SAMPLE_CAP) : 6'(cfg_samples);
               if (6'(rng_samples_done) >= n) begin
                  mean = (19'(rng_sum) + 19'(n >> 1)) / 19'(n);
                  rng_average = (mean > 19'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                                : mean[uer_pkg::DIST_W-1:0];
                  done = 1'b1;
                  rng_phase = uer_pkg::PH_IDLE;
                  rng_timer = '0;
               end else begin
                  rng_phase = uer_pkg::PH_TRIG;
                  rng_timer = uer_pkg::TIMER_W'(1);
                  rng_echo_count = '0;
               end
            end else begin
               rng_timer++;
            end
         end
         default: begin
            rng_phase = uer_pkg::PH_IDLE;
            rng_timer = '0;
         end
      endcase
      r.trigger_level = (rng_phase == uer_pkg::PH_TRIG);
      r.busy_res = (rng_phase != uer_pkg::PH_IDLE);
      r.done_res = done;
      r.distance_tenths_cm = rng_average;
      return r;
   endfunction

   // one tick transfer; returns at the rising edge that accepted it
   task automatic send_tick(input logic echo, input logic start);
      uer_pkg::rsp_payload_type predicted;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= '{echo_level: echo, start_request: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (rng_phase != uer_pkg::PH_IDLE || start) sequence_ticks++;
      predicted = step_ranger(echo, start);
      pending_readings.push_back(predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [uer_pkg::CSR_IDX_W-1:0] idx,
                            input logic [uer_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         uer_pkg::CSR_TRIGGER_WIDTH: cfg_trigger_width = value[uer_pkg::TRIG_W-1:0];
         uer_pkg::CSR_SAMPLES:       cfg_samples = value[uer_pkg::SAMP_W-1:0];
         uer_pkg::CSR_SAMPLE_GAP:    cfg_gap = value[uer_pkg::TIMER_W-1:0];
         uer_pkg::CSR_SCALE:         cfg_scale = value[uer_pkg::SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int trig, input int samples, input int gap,
                             input int scale);
      wait_drained();
      write_reg(uer_pkg::CSR_TRIGGER_WIDTH, uer_pkg::CSR_DATA_W'(trig));
      write_reg(uer_pkg::CSR_SAMPLES, uer_pkg::CSR_DATA_W'(samples));
      write_reg(uer_pkg::CSR_SAMPLE_GAP, uer_pkg::CSR_DATA_W'(gap));
      write_reg(uer_pkg::CSR_SCALE, uer_pkg::CSR_DATA_W'(scale));
   endtask

   // one echo sample from the trigger phase to the end of its gap
   task automatic run_sample(input int high_ticks);
      while (rng_phase == uer_pkg::PH_TRIG)
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      repeat (high_ticks) send_tick(1'b1, 1'($urandom_range(0, 1)));
      send_tick(1'b0, 1'($urandom_range(0, 1)));
      while (rng_phase == uer_pkg::PH_GAP)
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // start from idle and run samples until the average is stored
   task automatic run_measurement(input int first_high, input int high_limit);
      int taken;
      taken = 0;
      send_tick(1'($urandom_range(0, 1)), 1'b1);
      while (rng_phase != uer_pkg::PH_IDLE) begin
         run_sample((taken == 0 && first_high > 0) ? first_high
                                                   : $urandom_range(1, high_limit));
         taken++;
      end
   endtask

   task automatic test_reset_state();
      idling_on = 1'b0;
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      idling_on = 1'b1;
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
   endtask

   // data bits above a register's width are dropped; unused indexes do nothing
   task automatic test_register_map();
      logic [uer_pkg::CSR_IDX_W-1:0] idx;
      wait_drained();
      write_reg(uer_pkg::CSR_TRIGGER_WIDTH, 18'h3FF03);
      write_reg(uer_pkg::CSR_SAMPLES, 18'h3FFE2);
      write_reg(uer_pkg::CSR_SAMPLE_GAP, '1);
      write_reg(uer_pkg::CSR_SCALE, '1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      wait_drained();
      write_reg(uer_pkg::CSR_SAMPLE_GAP, 18'h00002);
      for (int i = int'(uer_pkg::CSR_SCALE) + 1; i < (1 << uer_pkg::CSR_IDX_W); i++) begin
         idx = uer_pkg::CSR_IDX_W'(i);
         write_reg(idx, uer_pkg::CSR_DATA_W'($urandom));
      end
      run_measurement(0, 12);
   endtask

   task automatic test_trigger_widths();
      int widths[3] = '{0, 1, 255};
      foreach (widths[i]) begin
         set_config(widths[i], 1, 1, uer_pkg::SCALE_RST);
         run_measurement(0, 8);
      end
   endtask

   // zero acts as one, counts above the cap act as the cap
   task automatic test_sample_counts();
      int counts[4] = '{0, 2, 16, 31};
      foreach (counts[i]) begin
         set_config(2, counts[i], 0, $urandom_range(0, 65535));
         run_measurement(0, 6);
      end
   endtask

   task automatic test_scale_extremes();
      set_config(1, 3, 0, 0);
      run_measurement(0, 30);
      idling_on = 1'b0;
      set_config(1, 2, 1, 65535);
      run_measurement(DIST_SAT_HIGH_TICKS, 10);
      idling_on = 1'b1;
   endtask

   task automatic test_echo_saturation();
      idling_on = 1'b0;
      set_config(1, 1, 0, 8192);
      run_measurement(SAT_HIGH_TICKS, 1);
      idling_on = 1'b1;
   endtask

   task automatic test_random_sequences();
      int base;
      int trig;
      int samples;
      int gap;
      int scale;
      int high_limit;
      base = sequence_ticks;
      while (sequence_ticks - base < RANDOM_TICKS) begin
         idling_on = ($urandom_range(0, 3) != 0)
                     && (sequence_ticks - base < RANDOM_TICKS - QUIET_TAIL);
         samples = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 31);
         case ($urandom_range(0, 7))
            0: trig = 0;
            1: trig = (samples <= 2) ? 255 : 1;
            default: trig = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 15))
            0, 1, 2, 3: gap = 0;
            4: gap = $urandom_range(90, 110);
            default: gap = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 7))
            0: scale = 0;
            1: scale = 65535;
            default: scale = $urandom_range(0, 65535);
         endcase
         high_limit = ($urandom_range(0, 15) == 0) ? 400 : $urandom_range(1, 40);
         set_config(trig, samples, gap, scale);
         // noise: echo wiggles while idle, no start
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(0, 1)), 1'b0);
         run_measurement(0, high_limit);
      end
      idling_on = 1'b0;
   endtask

   initial begin
      reset_ranger();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_map();
      test_trigger_widths();
      test_sample_counts();
      test_scale_extremes();
      test_echo_saturation();
      test_random_sequences();
      wait_drained();
      repeat (30) @(posedge clock);
      if (pending_readings.size() != 0) begin
         $error("%0d rsp transfers never arrived", pending_readings.size());
         failures++;
      end
      if (failures == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: files.f
hdl/uer_pkg.sv
hdl/uer_ctrl.sv
hdl/uer_dpath.sv
hdl/ultrasonic_echo_ranger_unit.sv
bench/tb_top.sv
